// ===== design/dfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_BANG = 8'h21;
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_AMP  = 8'h26;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_FRAME   = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic        last_payload;
        logic [15:0] frame_length;
        logic [7:0]  check_byte;
    } result_t;

endpackage

`default_nettype wire

// ===== design/dfr_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfr_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      rx_byte,
    output dfr_pkg::result_t     result,
    output logic                 result_valid
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BANG,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_STAR,
        PH_CHECK,
        PH_AMP
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] length_reg;
    logic [15:0] length_next;
    logic [15:0] position_reg;
    logic [15:0] position_next;
    logic [7:0]  check_reg;
    logic [7:0]  check_next;
    logic        is_last;
    logic [15:0] length_full;

    assign is_last     = position_reg >= (length_reg - 16'd1);
    assign length_full = {length_reg[15:8], rx_byte};

    always_comb
    begin
        phase_next    = phase_reg;
        length_next   = length_reg;
        position_next = position_reg;
        check_next    = check_reg;
        result_valid  = 1'b0;
        result        = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (rx_byte == dfr_pkg::CHAR_HASH)
                begin
                    phase_next = PH_BANG;
                end
            end
            PH_BANG:
            begin
                if (rx_byte == dfr_pkg::CHAR_BANG)
                begin
                    phase_next = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                length_next = {rx_byte, 8'h00};
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next   = length_full;
                position_next = '0;
                phase_next    = (length_full == 16'd0) ? PH_STAR : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                result_valid        = accept;
                result.kind         = dfr_pkg::KIND_PAYLOAD;
                result.payload_byte = rx_byte;
                result.byte_index   = position_reg;
                result.last_payload = is_last;
                result.frame_length = length_reg;
                if (is_last)
                begin
                    position_next = '0;
                    phase_next    = PH_STAR;
                end
                else
                begin
                    position_next = position_reg + 16'd1;
                end
            end
            PH_STAR:
            begin
                if (rx_byte == dfr_pkg::CHAR_STAR)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                check_next = rx_byte;
                phase_next = PH_AMP;
            end
            PH_AMP:
            begin
                if (rx_byte == dfr_pkg::CHAR_AMP)
                begin
                    result_valid        = accept;
                    result.kind         = dfr_pkg::KIND_FRAME;
                    result.frame_length = length_reg;
                    result.check_byte   = check_reg;
                    phase_next          = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            length_reg   <= '0;
            position_reg <= '0;
            check_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            length_reg   <= length_next;
            position_reg <= position_next;
            check_reg    <= check_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/dfr_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfr_out (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire dfr_pkg::result_t push_data,
    output logic                 push_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output dfr_pkg::result_t     out_data
);

    logic             main_valid_reg;
    logic             main_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    dfr_pkg::result_t main_reg;
    dfr_pkg::result_t main_next;
    dfr_pkg::result_t skid_reg;
    dfr_pkg::result_t skid_next;
    logic             pop;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;
    assign pop        = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

// ===== design/length_prefixed_frame_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result enters the output stage (result register, or skid while that is full) when its byte is transferred.
// Throughput: one byte per cycle while in_ready is high; the frame state updates once per accepted byte.
// A two-entry output stage (result register plus skid) lets input run while output stalls, until both are full.
// Reset: rst_n asynchronous, active low; clears the frame phase to awaiting the hash
// and empties the output stage.

module length_prefixed_frame_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic [7:0]       payload_byte,
    output logic [15:0]      byte_index,
    output logic             last_payload,
    output logic [15:0]      frame_length,
    output logic [7:0]       check_byte
);

    logic             accept;
    logic             result_valid;
    dfr_pkg::result_t result;
    dfr_pkg::result_t out_data;

    assign accept = in_valid && in_ready;

    dfr_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (rx_byte),
        .result       (result),
        .result_valid (result_valid)
    );

    dfr_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (result_valid),
        .push_data  (result),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign result_kind  = out_data.kind;
    assign payload_byte = out_data.payload_byte;
    assign byte_index   = out_data.byte_index;
    assign last_payload = out_data.last_payload;
    assign frame_length = out_data.frame_length;
    assign check_byte   = out_data.check_byte;

endmodule

`default_nettype wire
